// ===== rtl/core/fma_pkg.sv =====
package fma_pkg;

  // Fixed field widths of the request, response and configuration channels
  localparam int SLOT_W     = 4;
  localparam int AMOUNT_W   = 16;
  localparam int LEFT_W     = 16;
  localparam int FREE_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Request action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLES_IN_USE = 2'd1;

  // Placement policy codes; any other code acts as first fit
  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  localparam logic [4:0] HOLES_IN_USE_RST = 5'd16;

  typedef struct packed {
    logic                action;
    logic [SLOT_W-1:0]   slot;
    logic [AMOUNT_W-1:0] amount;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] chosen_slot;
    logic [LEFT_W-1:0] left_in_hole;
    logic [FREE_W-1:0] free_total;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

endpackage

// ===== rtl/core/fma_chan_if.sv =====
interface fma_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/fma_ram.sv =====
module fma_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/fit_memory_allocator.sv =====
// Hole-table allocator. A load request writes one hole size (slot, amount) and is
// acknowledged; an allocate request carries a size and takes a hole among the first
// holes_in_use entries by first, best or worst fit (ties to the lowest index), which
// then shrinks by the request. Every request yields one response with the grant
// flag, the hole index, that hole's remaining size and the total free space of the
// holes in use (the external fragmentation when nothing fits). The table lives in
// one single-port-write RAM; per-entry valid flops clear it at reset, so there is
// no clearing pass. Each request is served by one pass of the scan unit over the
// holes in use, one RAM read per cycle, plus a table write step (load: before the
// scan, allocation: after it) and a finish step that waits on the output register.
// in_ready is high only between requests, but a new request may be taken while
// the previous response still waits on the output register. Configuration
// writes are always accepted and must only be issued while the block is idle.
module fit_memory_allocator
  import fma_pkg::*;
#(
  parameter int HOLE_COUNT = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fma_chan_if.sink    req_i,
  fma_chan_if.source  rsp_o,
  fma_chan_if.sink    cfg_i
);

  localparam int IDX_W = $clog2(HOLE_COUNT);
  localparam int CNT_W = $clog2(HOLE_COUNT + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LWR  = 3'd1;  // load write
  localparam logic [2:0] ST_SCAN = 3'd2;  // read every hole in use
  localparam logic [2:0] ST_AWR  = 3'd3;  // allocation write-back
  localparam logic [2:0] ST_FIN  = 3'd4;  // hand result to output register

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0] fit_mode_q;
  logic [4:0] holes_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= MODE_FIRST;
      holes_q    <= HOLES_IN_USE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        REG_FIT_MODE:     fit_mode_q <= cfg_i.payload.data[1:0];
        REG_HOLES_IN_USE: holes_q    <= cfg_i.payload.data;
        default:          ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and scan unit registers
  // ---------------------------------------------------------------------------
  logic [2:0]           state_q, state_d;
  logic                 action_q, action_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic                 slot_ok_q, slot_ok_d;
  logic [SIZE_BITS-1:0] amt_q, amt_d;
  logic [CNT_W-1:0]     n_q, n_d;         // holes taking part, saturated
  logic [CNT_W-1:0]     issue_q, issue_d; // next entry to read
  logic                 rd_pend_q, rd_pend_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     pick_q, pick_d;
  logic [SIZE_BITS-1:0] pick_size_q, pick_size_d;
  logic [FREE_W-1:0]    acc_q, acc_d;
  logic [SIZE_BITS-1:0] left_q, left_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 out_q, out_d;

  logic [HOLE_COUNT-1:0] valid_q;

  // RAM port signals
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [SIZE_BITS-1:0] ram_rdata;

  fma_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (HOLE_COUNT)
  ) u_hole_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entries never written since reset read as empty holes
  logic [SIZE_BITS-1:0] rd_val;
  assign rd_val = rd_vld_q ? ram_rdata : '0;

  logic req_fire;
  logic fits, better;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // Shared compare: fit test plus best/worst tie-break against the current pick
  assign fits = (rd_val >= amt_q);
  always_comb begin
    case (fit_mode_q)
      MODE_BEST:  better = (rd_val < pick_size_q);
      MODE_WORST: better = (rd_val > pick_size_q);
      default:    better = 1'b0;  // first fit keeps the lowest index
    endcase
  end

  always_comb begin
    state_d     = state_q;
    action_d    = action_q;
    slot_d      = slot_q;
    slot_ok_d   = slot_ok_q;
    amt_d       = amt_q;
    n_d         = n_q;
    issue_d     = issue_q;
    rd_pend_d   = 1'b0;
    rd_vld_d    = rd_vld_q;
    rd_idx_d    = rd_idx_q;
    found_d     = found_q;
    pick_d      = pick_q;
    pick_size_d = pick_size_q;
    acc_d       = acc_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = pick_q;
    ram_wdata   = pick_size_q - amt_q;
    ram_re      = 1'b0;
    ram_raddr   = issue_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          action_d  = req_i.payload.action;
          slot_d    = req_i.payload.slot;
          slot_ok_d = (32'(req_i.payload.slot) < HOLE_COUNT);
          amt_d     = SIZE_BITS'(req_i.payload.amount);
          n_d       = (32'(holes_q) > HOLE_COUNT) ? CNT_W'(HOLE_COUNT) : CNT_W'(holes_q);
          issue_d   = '0;
          found_d   = 1'b0;
          pick_d    = '0;
          acc_d     = '0;
          left_d    = '0;
          state_d   = (req_i.payload.action == ACT_ALLOC) ? ST_SCAN : ST_LWR;
        end
      end
      ST_LWR: begin
        ram_we    = slot_ok_q;
        ram_waddr = IDX_W'(slot_q);
        ram_wdata = amt_q;
        found_d   = slot_ok_q;
        pick_d    = slot_ok_q ? IDX_W'(slot_q) : '0;
        left_d    = slot_ok_q ? amt_q : '0;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        if (issue_q < n_q) begin
          ram_re    = 1'b1;
          rd_pend_d = 1'b1;
          rd_vld_d  = valid_q[issue_q[IDX_W-1:0]];
          rd_idx_d  = issue_q[IDX_W-1:0];
          issue_d   = issue_q + 1'b1;
        end
        if (rd_pend_q) begin
          acc_d = acc_q + FREE_W'(rd_val);
          if (action_q == ACT_ALLOC && fits) begin
            if (!found_q || better) begin
              found_d     = 1'b1;
              pick_d      = rd_idx_q;
              pick_size_d = rd_val;
            end
          end
        end
        if (issue_q == n_q && !rd_pend_q) begin
          state_d = (action_q == ACT_ALLOC) ? ST_AWR : ST_FIN;
        end
      end
      ST_AWR: begin
        ram_we = found_q;
        if (found_q) begin
          left_d = pick_size_q - amt_q;
          acc_d  = acc_q - FREE_W'(amt_q);
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d        = 1'b1;
          out_d.granted      = found_q;
          out_d.chosen_slot  = found_q ? SLOT_W'(pick_q) : '0;
          out_d.left_in_hole = LEFT_W'(left_q);
          out_d.free_total   = acc_q;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      action_q    <= ACT_LOAD;
      slot_q      <= '0;
      slot_ok_q   <= 1'b0;
      amt_q       <= '0;
      n_q         <= '0;
      issue_q     <= '0;
      rd_pend_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      found_q     <= 1'b0;
      pick_q      <= '0;
      pick_size_q <= '0;
      acc_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      action_q    <= action_d;
      slot_q      <= slot_d;
      slot_ok_q   <= slot_ok_d;
      amt_q       <= amt_d;
      n_q         <= n_d;
      issue_q     <= issue_d;
      rd_pend_q   <= rd_pend_d;
      rd_vld_q    <= rd_vld_d;
      rd_idx_q    <= rd_idx_d;
      found_q     <= found_d;
      pick_q      <= pick_d;
      pick_size_q <= pick_size_d;
      acc_q       <= acc_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // Per-entry written flags stand in for clearing the table at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[ram_waddr] <= 1'b1;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

`ifndef SYNTHESIS
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_LWR || state_q == ST_AWR))
    else $error("hole table written outside a write state");

  a_alloc_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.payload.action == ACT_ALLOC) |=> state_q == ST_SCAN)
    else $error("allocate request did not start a scan");

  a_pick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AWR && found_q) |-> CNT_W'(pick_q) < n_q)
    else $error("picked hole outside the holes in use");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> issue_q <= n_q)
    else $error("scan ran past the holes in use");

  a_rsp_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("response raised outside the finish step");
`endif

endmodule

// ===== tb/sv/fit_memory_allocator_test.sv =====
`timescale 1ns / 1ps

module fit_memory_allocator_test;
  import fma_pkg::*;

  localparam int HOLE_COUNT = 16;
  localparam int SIZE_BITS  = 16;
  // Run limit in cycles, well above what a correct run needs
  localparam int CYCLE_LIMIT = 400_000;
  // Sets the length of a forced stretch in which the response side holds ready low
  localparam int HOLD_CYCLES = 300;
  // Quiet time after the last response, in cycles
  localparam int TAIL_CYCLES = 60;
  localparam int SEGMENTS     = 30;
  localparam int SEG_REQUESTS = 50;

  // Codes the package leaves unnamed: a spare policy code and an unmapped register
  localparam logic [1:0]           MODE_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef enum int {STEP_REQ, STEP_CFG, STEP_DRAIN, STEP_PHASE, STEP_HOLD} step_kind_e;

  typedef struct {
    step_kind_e kind;
    req_t       req;
    cfg_t       cfg;
    int         src_idle;  // percent of cycles the request side stays quiet
    int         snk_idle;  // percent of cycles the response side drops ready
  } step_t;

  logic clk_i;
  logic rst_ni;

  fma_chan_if #(.payload_t(req_t)) req_if ();
  fma_chan_if #(.payload_t(rsp_t)) rsp_if ();
  fma_chan_if #(.payload_t(cfg_t)) cfg_if ();

  fit_memory_allocator #(
    .HOLE_COUNT(HOLE_COUNT),
    .SIZE_BITS (SIZE_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the allocator: hole table and both registers, as after reset.
  // ---------------------------------------------------------------------------
  logic [SIZE_BITS-1:0] hole_tbl [HOLE_COUNT];
  logic [1:0]           mode_q;
  logic [4:0]           in_use_q;

  step_t stim_plan[$];      // requests, register writes and control markers, in order
  rsp_t  predicted_rsps[$]; // one per accepted request, oldest first

  int errors;
  int cycles;
  int n_loads, n_allocs, n_grants, n_fails, n_cfg;

  // Handshake seen at the last rising edge, read by the driver at the falling edge
  logic req_fire, cfg_fire;

  int src_idle_pct, snk_idle_pct;
  int hold_asks, hold_done, hold_left;

  // Serve one request against the shadow table and return the response it causes.
  // Candidates are compared on their current size; ties keep the lower index.
  function automatic rsp_t serve_request(req_t r);
    rsp_t              res;
    int                n;
    int                i;
    int                pick;
    bit                found;
    logic [FREE_W-1:0] sum;
    res = '0;
    if (r.action == ACT_LOAD) begin
      // a slot past the table is refused and leaves it alone
      if (int'(r.slot) < HOLE_COUNT) begin
        hole_tbl[r.slot] = r.amount;
        res.granted      = 1'b1;
        res.chosen_slot  = r.slot;
        res.left_in_hole = r.amount;
      end
    end else begin
      n     = (in_use_q > HOLE_COUNT) ? HOLE_COUNT : int'(in_use_q);
      found = 0;
      pick  = 0;
      for (i = 0; i < n; i++) begin
        if (hole_tbl[i] >= r.amount) begin
          if (!found) begin
            found = 1;
            pick  = i;
          end else if (mode_q == MODE_BEST && hole_tbl[i] < hole_tbl[pick]) begin
            pick = i;
          end else if (mode_q == MODE_WORST && hole_tbl[i] > hole_tbl[pick]) begin
            pick = i;
          end
          // first fit and the spare code keep the first candidate
        end
      end
      if (found) begin
        hole_tbl[pick]   = hole_tbl[pick] - r.amount;
        res.granted      = 1'b1;
        res.chosen_slot  = pick[SLOT_W-1:0];
        res.left_in_hole = hole_tbl[pick];
      end
    end
    // free total covers only the holes in use, after the update
    n   = (in_use_q > HOLE_COUNT) ? HOLE_COUNT : int'(in_use_q);
    sum = '0;
    for (i = 0; i < n; i++) sum = sum + hole_tbl[i];
    res.free_total = sum;
    return res;
  endfunction

  task automatic check_field(string name, longint unsigned exp, longint unsigned got);
    if (exp != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp, got);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Plan builders
  // ---------------------------------------------------------------------------
  task automatic add_req(logic action, int slot, int amount);
    step_t s;
    s            = '{default: 0, kind: STEP_REQ, req: '0, cfg: '0};
    s.req.action = action;
    s.req.slot   = slot[SLOT_W-1:0];
    s.req.amount = amount[AMOUNT_W-1:0];
    stim_plan.push_back(s);
  endtask

  // A register write always waits for the block to go idle first
  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, int data);
    step_t s;
    s           = '{default: 0, kind: STEP_CFG, req: '0, cfg: '0};
    s.cfg.index = idx;
    s.cfg.data  = data[CFG_DATA_W-1:0];
    stim_plan.push_back(s);
  endtask

  task automatic add_marker(step_kind_e kind, int src_pct, int snk_pct);
    step_t s;
    s          = '{default: 0, kind: kind, req: '0, cfg: '0};
    s.src_idle = src_pct;
    s.snk_idle = snk_pct;
    stim_plan.push_back(s);
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses outstanding",
               cycles, predicted_rsps.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: one plan step at a time, inputs change on the falling edge.
  // Next values are worked out first so each signal gets one assignment per edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic  nxt_req_valid;
    logic  nxt_cfg_valid;
    req_t  nxt_req;
    cfg_t  nxt_cfg;
    step_t s;
    if (rst_ni) begin
      nxt_req_valid = req_if.valid;
      nxt_cfg_valid = cfg_if.valid;
      nxt_req       = req_if.payload;
      nxt_cfg       = cfg_if.payload;
      if (req_fire) nxt_req_valid = 1'b0;
      if (cfg_fire) nxt_cfg_valid = 1'b0;
      if (!nxt_req_valid && !nxt_cfg_valid && stim_plan.size() > 0) begin
        s = stim_plan[0];
        case (s.kind)
          STEP_REQ: begin
            if ($urandom_range(0, 99) >= src_idle_pct) begin
              nxt_req_valid = 1'b1;
              nxt_req       = s.req;
              void'(stim_plan.pop_front());
            end
          end
          STEP_CFG: begin
            // idle means every request so far has its response back
            if (predicted_rsps.size() == 0) begin
              nxt_cfg_valid = 1'b1;
              nxt_cfg       = s.cfg;
              void'(stim_plan.pop_front());
            end
          end
          STEP_DRAIN: begin
            if (predicted_rsps.size() == 0) void'(stim_plan.pop_front());
          end
          STEP_PHASE: begin
            src_idle_pct <= s.src_idle;
            snk_idle_pct <= s.snk_idle;
            void'(stim_plan.pop_front());
          end
          STEP_HOLD: begin
            hold_asks <= hold_asks + 1;
            void'(stim_plan.pop_front());
          end
          default: void'(stim_plan.pop_front());
        endcase
      end
      req_if.valid   <= nxt_req_valid;
      req_if.payload <= nxt_req;
      cfg_if.valid   <= nxt_cfg_valid;
      cfg_if.payload <= nxt_cfg;
    end
  end

  // Response side: random ready, or a long hold-off when the driver asks for one
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_done != hold_asks) begin
        hold_done <= hold_asks;
        hold_left <= HOLD_CYCLES;
        rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples all three channels on the rising edge. The response is
  // checked before a request of the same edge is predicted; it cannot belong
  // to that request.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp;
    rsp_t got;
    if (!rst_ni) begin
      req_fire <= 1'b0;
      cfg_fire <= 1'b0;
    end else begin
      req_fire <= req_if.valid && req_if.ready;
      cfg_fire <= cfg_if.valid && cfg_if.ready;
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.payload;
        if (predicted_rsps.size() == 0) begin
          $error("response with no request outstanding: granted %0d slot %0d left %0d free %0d",
                 got.granted, got.chosen_slot, got.left_in_hole, got.free_total);
          errors++;
        end else begin
          exp = predicted_rsps.pop_front();
          check_field("granted", exp.granted, got.granted);
          check_field("chosen_slot", exp.chosen_slot, got.chosen_slot);
          check_field("left_in_hole", exp.left_in_hole, got.left_in_hole);
          check_field("free_total", exp.free_total, got.free_total);
          if (got.granted) n_grants++;
          else n_fails++;
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        n_cfg++;
        if (cfg_if.payload.index == REG_FIT_MODE) mode_q = cfg_if.payload.data[1:0];
        else if (cfg_if.payload.index == REG_HOLES_IN_USE) in_use_q = cfg_if.payload.data;
      end
      if (req_if.valid && req_if.ready) begin
        if (req_if.payload.action == ACT_LOAD) n_loads++;
        else n_allocs++;
        predicted_rsps.push_back(serve_request(req_if.payload));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int seg;
    int k;
    int use_cnt;
    int amt;
    // every input known from time zero
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    rsp_if.ready   = 1'b0;
    errors = 0; cycles = 0;
    n_loads = 0; n_allocs = 0; n_grants = 0; n_fails = 0; n_cfg = 0;
    src_idle_pct = 0; snk_idle_pct = 0;
    hold_asks = 0; hold_done = 0; hold_left = 0;
    for (k = 0; k < HOLE_COUNT; k++) hole_tbl[k] = '0;
    mode_q   = MODE_FIRST;
    in_use_q = HOLES_IN_USE_RST;

    // --- directed part ---
    add_marker(STEP_PHASE, 24, 47);
    add_req(ACT_ALLOC, 0, 1);         // empty table: fails, free total 0
    add_req(ACT_ALLOC, 9, 0);         // zero request fits the empty hole 0
    add_req(ACT_LOAD, 0, 65535);
    add_req(ACT_LOAD, 15, 65535);
    add_req(ACT_LOAD, 3, 100);
    add_req(ACT_LOAD, 5, 50);
    add_req(ACT_LOAD, 7, 100);
    add_req(ACT_ALLOC, 0, 60);        // first fit: hole 0
    add_req(ACT_ALLOC, 0, 65535);     // only hole 15 fits, drops to 0
    add_cfg(REG_FIT_MODE, MODE_BEST);
    add_req(ACT_ALLOC, 0, 40);        // smallest fitting: hole 5
    add_req(ACT_ALLOC, 0, 100);       // holes 3 and 7 tie, lower index wins
    add_cfg(REG_FIT_MODE, MODE_WORST);
    add_req(ACT_LOAD, 0, 500);
    add_req(ACT_LOAD, 7, 500);
    add_req(ACT_ALLOC, 0, 1);         // largest tie between 0 and 7
    add_cfg(REG_FIT_MODE, {3'b111, MODE_SPARE});  // spare code, acts as first fit
    add_req(ACT_ALLOC, 0, 10);
    add_cfg(REG_HOLES_IN_USE, 4);
    add_req(ACT_LOAD, 10, 65535);     // outside the holes in use
    add_req(ACT_ALLOC, 0, 600);       // nothing in use fits: fragmentation
    add_cfg(REG_HOLES_IN_USE, 0);
    add_req(ACT_ALLOC, 0, 0);         // no holes in use: even zero fails
    add_cfg(REG_HOLES_IN_USE, 31);    // saturates to the table size
    add_req(ACT_ALLOC, 0, 65535);     // hole 10 now counts
    add_cfg(REG_UNMAPPED, 0);         // ignored
    add_cfg(REG_HOLES_IN_USE, 1);
    add_cfg(REG_FIT_MODE, MODE_FIRST);
    add_req(ACT_ALLOC, 0, 0);
    add_req(ACT_LOAD, 1, 0);

    // --- random part: segments of one setting each ---
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == SEGMENTS / 3) add_marker(STEP_PHASE, 47, 24);
      if (seg == 2 * SEGMENTS / 3) add_marker(STEP_PHASE, 0, 0);
      add_marker(STEP_DRAIN, 0, 0);   // sender pauses until all responses are back
      add_cfg(REG_FIT_MODE, {3'($urandom_range(0, 7)), 2'($urandom_range(0, 3))});
      case ($urandom_range(0, 9))
        0:       use_cnt = $urandom_range(17, 31);
        1:       use_cnt = 0;
        2:       use_cnt = 1;
        3, 4:    use_cnt = HOLE_COUNT;
        default: use_cnt = $urandom_range(1, HOLE_COUNT);
      endcase
      add_cfg(REG_HOLES_IN_USE, use_cnt);
      if (seg == 4 || seg == 14) add_marker(STEP_HOLD, 0, 0);
      for (k = 0; k < SEG_REQUESTS; k++) begin
        if ($urandom_range(0, 99) < 40) begin
          case ($urandom_range(0, 3))
            0:       amt = $urandom_range(0, 65535);
            1:       amt = $urandom_range(1, 8) * 256;  // repeats make ties
            2:       amt = $urandom_range(0, 1023);
            default: amt = ($urandom_range(0, 1) == 1) ? 65535 : 0;
          endcase
          add_req(ACT_LOAD, $urandom_range(0, 15), amt);
        end else begin
          case ($urandom_range(0, 4))
            0:       amt = 0;
            1:       amt = $urandom_range(0, 255);
            2:       amt = $urandom_range(0, 2047);
            3:       amt = $urandom_range(0, 65535);
            default: amt = $urandom_range(1, 8) * 256;
          endcase
          // slot is a don't-care for allocations but still gets exercised
          add_req(ACT_ALLOC, $urandom_range(0, 15), amt);
        end
      end
    end

    // reset held from time zero, released on a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (stim_plan.size() > 0 || req_if.valid || cfg_if.valid || predicted_rsps.size() > 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (predicted_rsps.size() != 0) begin
      $error("%0d responses never arrived", predicted_rsps.size());
      errors++;
    end

    $display("Covered %0d loads and %0d allocations (%0d granted, %0d refused)",
             n_loads, n_allocs, n_grants, n_fails);
    $display("across %0d register writes, all fit policies and a held-off response side",
             n_cfg);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
